@@ hdl/i2csrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb_pkg
// Shared types, codes and helpers for the I2C slave register bridge.
// ----------------------------------------------------------------------------
package i2csrb_pkg;

	localparam logic [2:0] TOP_BIT = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ADDR     = 3'd1,
		PH_DATA     = 3'd2,
		PH_ACK_ADDR = 3'd3,
		PH_ACK_DATA = 3'd4,
		PH_SEND     = 3'd5,
		PH_MACK     = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_START = 3'd1,
		EV_STOP  = 3'd2,
		EV_ADDR  = 3'd3,
		EV_ABORT = 3'd4
	} event_t;

	// one line sample plus the bus answer
	typedef struct packed {
		logic [7:0] read_data;
		logic       sda_level;
		logic       scl_level;
	} item_t;

	// one result word
	typedef struct packed {
		event_t     bus_event;
		logic [7:0] bus_write_data;
		logic [7:0] bus_address;
		logic       bus_read;
		logic       bus_write;
		logic       sda_release;
	} result_t;

	// bit position within a byte for a given bit count
	function automatic logic [2:0] bit_pos(input logic [3:0] idx, input logic lsb_first);
		return lsb_first ? idx[2:0] : (TOP_BIT - idx[2:0]);
	endfunction

endpackage

@@ hdl/i2csrb_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb_core
// Protocol state and single-pass step logic: one line sample per step.
// ----------------------------------------------------------------------------
module i2csrb_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                step,
	input  i2csrb_pkg::item_t   item,
	output i2csrb_pkg::result_t res
);
	import i2csrb_pkg::*;

	logic       lsb_first_q;
	logic       scl_before_q, scl_before_d;
	logic       sda_before_q, sda_before_d;
	phase_t     phase_q, phase_d;
	logic [3:0] bit_index_q, bit_index_d;
	logic [7:0] shift_byte_q, shift_byte_d;
	logic       bit_at_rise_q, bit_at_rise_d;
	logic [7:0] target_addr_q, target_addr_d;
	logic       have_addr_q, have_addr_d;
	logic [7:0] tx_byte_q, tx_byte_d;
	logic       read_pend_q, read_pend_d;

	logic       rise, fall;
	logic [3:0] bit_inc;
	event_t     ev;
	logic       wr, rdq, rel;
	logic [7:0] wdata;

	assign rise    = !scl_before_q && item.scl_level;
	assign fall    = scl_before_q && !item.scl_level;
	assign bit_inc = bit_index_q + 4'd1;

	always_comb begin
		scl_before_d  = item.scl_level;
		sda_before_d  = item.sda_level;
		phase_d       = phase_q;
		bit_index_d   = bit_index_q;
		shift_byte_d  = shift_byte_q;
		bit_at_rise_d = bit_at_rise_q;
		target_addr_d = target_addr_q;
		have_addr_d   = have_addr_q;
		tx_byte_d     = tx_byte_q;
		read_pend_d   = read_pend_q;
		ev            = EV_NONE;
		wr            = 1'b0;
		rdq           = 1'b0;
		wdata         = 8'd0;
		rel           = 1'b1;

		// bus answer arrives one step after the read request
		if (read_pend_q) begin
			tx_byte_d   = item.read_data;
			read_pend_d = 1'b0;
		end
		if (rise) begin
			bit_at_rise_d = item.sda_level;
		end

		unique case (phase_q)
			PH_ADDR, PH_DATA: begin
				if (fall) begin
					if (bit_at_rise_d == sda_before_q) begin
						shift_byte_d = shift_byte_q
							| (8'(bit_at_rise_d) << bit_pos(bit_index_q, lsb_first_q));
						if (bit_index_q >= 4'(TOP_BIT)) begin
							phase_d     = (phase_q == PH_ADDR) ? PH_ACK_ADDR : PH_ACK_DATA;
							bit_index_d = 4'd0;
						end else begin
							bit_index_d = bit_inc;
						end
					end else begin
						// SDA moved while SCL high: stop if it rose, else abort
						ev          = bit_at_rise_d ? EV_ABORT : EV_STOP;
						phase_d     = PH_IDLE;
						bit_index_d = 4'd0;
					end
				end
			end
			PH_ACK_ADDR: begin
				if (fall) begin
					ev          = EV_ADDR;
					have_addr_d = 1'b0;
					bit_index_d = 4'd0;
					if (shift_byte_q[0]) begin
						rdq         = 1'b1;
						read_pend_d = 1'b1;
						phase_d     = PH_SEND;
					end else begin
						phase_d      = PH_DATA;
						shift_byte_d = 8'd0;
					end
				end
			end
			PH_ACK_DATA: begin
				if (fall) begin
					if (!have_addr_q) begin
						target_addr_d = shift_byte_q;
						have_addr_d   = 1'b1;
					end else begin
						wr          = 1'b1;
						wdata       = shift_byte_q;
						have_addr_d = 1'b0;
					end
					phase_d      = PH_DATA;
					bit_index_d  = 4'd0;
					shift_byte_d = 8'd0;
				end
			end
			PH_SEND: begin
				if (fall) begin
					if (bit_inc > 4'(TOP_BIT)) begin
						phase_d     = PH_MACK;
						bit_index_d = 4'd0;
					end else begin
						bit_index_d = bit_inc;
					end
				end
			end
			PH_MACK: begin
				if (fall) begin
					bit_index_d = 4'd0;
					if (bit_at_rise_d == sda_before_q) begin
						if (!bit_at_rise_d) begin
							// master ACK: fetch the next byte
							rdq         = 1'b1;
							read_pend_d = 1'b1;
							have_addr_d = 1'b0;
							phase_d     = PH_SEND;
						end else begin
							phase_d = PH_IDLE;
						end
					end else begin
						ev      = bit_at_rise_d ? EV_ABORT : EV_STOP;
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.scl_level && scl_before_q && sda_before_q && !item.sda_level) begin
					ev           = EV_START;
					phase_d      = PH_ADDR;
					bit_index_d  = 4'd0;
					shift_byte_d = 8'd0;
				end
			end
		endcase

		if (phase_d == PH_ACK_ADDR || phase_d == PH_ACK_DATA) begin
			rel = 1'b0;
		end else if (phase_d == PH_SEND && !read_pend_d) begin
			rel = tx_byte_d[bit_pos(bit_index_d, lsb_first_q)];
		end
	end

	always_comb begin
		res.sda_release    = rel;
		res.bus_write      = wr;
		res.bus_read       = rdq;
		res.bus_address    = target_addr_d;
		res.bus_write_data = wdata;
		res.bus_event      = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_first_q   <= 1'b1;
			scl_before_q  <= 1'b1;
			sda_before_q  <= 1'b1;
			phase_q       <= PH_IDLE;
			bit_index_q   <= 4'd0;
			shift_byte_q  <= 8'd0;
			bit_at_rise_q <= 1'b0;
			target_addr_q <= 8'd0;
			have_addr_q   <= 1'b0;
			tx_byte_q     <= 8'd0;
			read_pend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				lsb_first_q <= cfg_wdata;
			end
			if (step) begin
				scl_before_q  <= scl_before_d;
				sda_before_q  <= sda_before_d;
				phase_q       <= phase_d;
				bit_index_q   <= bit_index_d;
				shift_byte_q  <= shift_byte_d;
				bit_at_rise_q <= bit_at_rise_d;
				target_addr_q <= target_addr_d;
				have_addr_q   <= have_addr_d;
				tx_byte_q     <= tx_byte_d;
				read_pend_q   <= read_pend_d;
			end
		end
	end

endmodule

@@ hdl/i2c_slave_register_bridge_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_register_bridge_top
// I2C slave that turns bus transfers into 8-bit register reads and writes.
// ----------------------------------------------------------------------------
// Each input word is one sample of SCL and SDA plus the register bus answer
// to the read request made in the previous result word. Every accepted word
// yields exactly one result word. Throughput is one word per clock while the
// result side does not stall; each word passes the input register, then the
// result register, with the single pass of the protocol step logic between
// them. The input register takes a word whenever it is empty or its word
// moves on in the same cycle; its word moves on when the result register is
// free or being drained in that cycle, so one word can wait in it while a
// result is stalled. Every address byte is ACKed. On a write,
// data bytes alternate between setting the register address and issuing a
// bus write; on a read, each byte issues a bus read of the stored address
// and is shifted out. cfg_we/cfg_wdata set lsb_first (reset 1: LSB first;
// 0: MSB first) and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module i2c_slave_register_bridge_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: lsb_first
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] scl_level, [1] sda_level, [9:2] read_data, rest 0
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] sda_release, [1] bus_write, [2] bus_read,
	                               // [10:3] bus_address, [18:11] bus_write_data,
	                               // [21:19] bus_event, rest 0
);
	import i2csrb_pkg::*;

	logic    in_valid_s1;
	item_t   item_s1;
	logic    out_valid_s2;
	result_t res_s2;
	result_t res;
	logic    advance;

	// move the held sample into the result register when it has room
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[9:0]);
		end
	end

	i2csrb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (advance),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {2'b00, res_s2.bus_event, res_s2.bus_write_data, res_s2.bus_address,
		res_s2.bus_read, res_s2.bus_write, res_s2.sda_release};

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed bus traffic for the I2C slave register bridge.
// ----------------------------------------------------------------------------
// Line samples are built from whole bus transactions: write frames with a
// register address and data pairs, read frames with ACK or NACK from the
// master, early stops, aborted bits, a start while busy and raw noise. The
// stream is sent in random bursts while the result side stalls on its own
// pattern. Each accepted word is run through a cycle-level predictor and each
// result word is checked field by field against the oldest prediction. The
// run steps through both bit orders, LSB first and MSB first, twice each.
// ----------------------------------------------------------------------------
module testbench;
	import i2csrb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // [0] scl_level, [1] sda_level, [9:2] read_data
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [0] sda_release, [1] bus_write, [2] bus_read,
	                               // [10:3] bus_address, [18:11] bus_write_data,
	                               // [21:19] bus_event

	i2c_slave_register_bridge_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the slave's state and its bit order.
	// ------------------------------------------------------------------------
	logic       lsb_mode;      // bit order as last written to the block
	logic       scl_q, sda_q;  // previous line sample
	phase_t     ph;
	logic [3:0] nbit;          // bits seen (or sent) in the current byte
	logic [7:0] rx_byte;
	logic       rise_bit;      // SDA caught at the last SCL rise
	logic       dir_rd;
	logic [7:0] target_addr;
	logic       addr_valid;    // next write byte is data, not an address
	logic [7:0] tx_byte;
	logic       rd_wait;       // bus answer arrives with the next word

	// testbench bookkeeping
	item_t      line_queue[$];       // samples waiting for the sender
	result_t    bus_results_due[$];  // predicted result words, oldest first
	int         words_queued = 0;
	int         words_taken = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	logic       in_taken = 1'b0;     // sender's word went through at the last edge
	logic       gen_lsb = 1'b1;      // bit order that the generator encodes for
	logic [8:0] rd_fix = '0;         // [8] set: bus answers use [7:0]

	// byte position of the n-th bit under the current bit order
	function automatic logic [2:0] shift_slot(input logic [3:0] n);
		return lsb_mode ? n[2:0] : 3'd7 - n[2:0];
	endfunction

	function automatic void drop_to_idle();
		ph = PH_IDLE;
		nbit = '0;
		dir_rd = 1'b0;
	endfunction

	function automatic void start_read();
		rd_wait = 1'b1;
		addr_valid = 1'b0;
		ph = PH_SEND;
		nbit = '0;
	endfunction

	// One line sample in, one result word out.
	function automatic result_t bridge_step(input item_t s);
		result_t r;
		logic    rise, fall;
		r = '0;
		r.sda_release = 1'b1;
		r.bus_event = EV_NONE;
		rise = !scl_q && s.scl_level;
		fall = scl_q && !s.scl_level;
		if (rd_wait) begin
			tx_byte = s.read_data;
			rd_wait = 1'b0;
		end
		if (rise)
			rise_bit = s.sda_level;
		case (ph)
			PH_ADDR, PH_DATA: begin
				if (fall) begin
					if (rise_bit == sda_q) begin
						rx_byte = rx_byte | (8'(rise_bit) << shift_slot(nbit));
						if (nbit >= 4'd7) begin
							ph = (ph == PH_ADDR) ? PH_ACK_ADDR : PH_ACK_DATA;
							nbit = '0;
						end else begin
							nbit = nbit + 4'd1;
						end
					end else begin
						// SDA moved while SCL was high
						r.bus_event = rise_bit ? EV_ABORT : EV_STOP;
						drop_to_idle();
					end
				end
			end
			PH_ACK_ADDR: begin
				if (fall) begin
					r.bus_event = EV_ADDR;
					dir_rd = rx_byte[0];
					if (dir_rd) begin
						r.bus_read = 1'b1;
						start_read();
					end else begin
						addr_valid = 1'b0;
						ph = PH_DATA;
						nbit = '0;
						rx_byte = '0;
					end
				end
			end
			PH_ACK_DATA: begin
				if (fall) begin
					if (!addr_valid) begin
						target_addr = rx_byte;
						addr_valid = 1'b1;
					end else begin
						r.bus_write = 1'b1;
						r.bus_write_data = rx_byte;
						addr_valid = 1'b0;
					end
					ph = PH_DATA;
					nbit = '0;
					rx_byte = '0;
				end
			end
			PH_SEND: begin
				if (fall) begin
					nbit = nbit + 4'd1;
					if (nbit > 4'd7) begin
						ph = PH_MACK;
						nbit = '0;
					end
				end
			end
			PH_MACK: begin
				if (fall) begin
					if (rise_bit == sda_q) begin
						// master ACK asks for another byte, NACK ends the read
						if (!rise_bit) begin
							r.bus_read = 1'b1;
							start_read();
						end else begin
							drop_to_idle();
						end
					end else begin
						r.bus_event = rise_bit ? EV_ABORT : EV_STOP;
						drop_to_idle();
					end
				end
			end
			default: begin
				ph = PH_IDLE;
				if (s.scl_level && scl_q && sda_q && !s.sda_level) begin
					r.bus_event = EV_START;
					dir_rd = 1'b0;
					ph = PH_ADDR;
					nbit = '0;
					rx_byte = '0;
				end
			end
		endcase
		if (ph == PH_ACK_ADDR || ph == PH_ACK_DATA)
			r.sda_release = 1'b0;
		else if (ph == PH_SEND && !rd_wait)
			r.sda_release = tx_byte[shift_slot(nbit)];
		scl_q = s.scl_level;
		sda_q = s.sda_level;
		r.bus_address = target_addr;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatches++;
		$display("%0t ns: result %0d %s got %0h expected %0h",
			$time, results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Monitor: predicts on every accepted input word, checks every result.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t got, want;
		if (arst_n) begin
			if (cfg_we)
				lsb_mode = cfg_wdata;
			if (s_tvalid && s_tready) begin
				bus_results_due.push_back(bridge_step(item_t'(s_tdata[9:0])));
				words_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[21:0]);
				results_seen++;
				if (bus_results_due.size() == 0) begin
					flag_mismatch("word with nothing predicted", '0, '0);
				end else begin
					want = bus_results_due.pop_front();
					if (got.sda_release !== want.sda_release)
						flag_mismatch("sda_release", 8'(got.sda_release),
							8'(want.sda_release));
					if (got.bus_write !== want.bus_write)
						flag_mismatch("bus_write", 8'(got.bus_write), 8'(want.bus_write));
					if (got.bus_read !== want.bus_read)
						flag_mismatch("bus_read", 8'(got.bus_read), 8'(want.bus_read));
					if (got.bus_address !== want.bus_address)
						flag_mismatch("bus_address", got.bus_address, want.bus_address);
					if (got.bus_write_data !== want.bus_write_data)
						flag_mismatch("bus_write_data", got.bus_write_data,
							want.bus_write_data);
					if (got.bus_event !== want.bus_event)
						flag_mismatch("bus_event", 8'(got.bus_event), 8'(want.bus_event));
					if (m_tdata[23:22] !== 2'b00)
						flag_mismatch("pad bits", 8'(m_tdata[23:22]), '0);
				end
			end
		end
		in_taken <= s_tvalid && s_tready;
	end

	// ------------------------------------------------------------------------
	// Sender: bursts of random length, random gaps, sometimes no gaps at all.
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : sender
		logic next_valid;
		next_valid = s_tvalid && !in_taken;   // hold until the word is taken
		if (arst_n && !next_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (line_queue.size() != 0) begin
				s_tdata <= {6'b0, line_queue.pop_front()};
				next_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		s_tvalid <= next_valid;
	end

	// ------------------------------------------------------------------------
	// Receiver: stall modes picked per stretch, from never to mostly stalled.
	// ------------------------------------------------------------------------
	int          stall_left = 0;
	int          stall_mode = 0;
	logic [31:0] stall_pat = '1;

	always @(negedge clk) begin : receiver
		logic rdy;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_pat = $urandom;
			stall_left = $urandom_range(16, 80);
		end
		stall_left--;
		stall_pat = {stall_pat[30:0], stall_pat[31]};
		case (stall_mode)
			0: rdy = 1'b1;
			1: rdy = stall_pat[0];
			2: rdy = stall_pat[0] | stall_pat[5];
			default: rdy = ($urandom_range(0, 3) == 0);
		endcase
		m_tready <= rdy;
	end

	// ------------------------------------------------------------------------
	// Stimulus building blocks. Each puts line samples on the send queue.
	// ------------------------------------------------------------------------
	task automatic put_sample(input logic scl, input logic sda);
		item_t s;
		s.scl_level = scl;
		s.sda_level = sda;
		s.read_data = rd_fix[8] ? rd_fix[7:0] : 8'($urandom);
		line_queue.push_back(s);
		words_queued++;
	endtask

	// one SCL pulse carrying bit b; the fall comes with the next sample
	task automatic clock_bit(input logic b);
		repeat ($urandom_range(1, 3)) put_sample(1'b0, b);
		repeat ($urandom_range(1, 3)) put_sample(1'b1, b);
	endtask

	// clock where the master does not drive: random SDA, sometimes moving
	task automatic clock_free();
		logic x;
		x = 1'($urandom_range(0, 1));
		repeat ($urandom_range(1, 3)) put_sample(1'b0, x);
		put_sample(1'b1, x);
		if ($urandom_range(0, 3) == 0)
			put_sample(1'b1, !x);
	endtask

	// Start condition. The SCL fall right after it is taken as the first
	// address bit, so the rise before it is set up to carry b0.
	task automatic start_frame(input logic b0);
		put_sample(1'b0, b0);
		put_sample(1'b1, b0);
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b0);
		if (b0)
			put_sample(1'b1, 1'b1);
	endtask

	// start, address byte with the direction in byte bit 0, ACK clock
	task automatic open_frame(input logic rw);
		logic [7:0] seq;
		seq = 8'($urandom);
		seq[gen_lsb ? 0 : 7] = rw;
		start_frame(seq[0]);
		for (int i = 1; i < 8; i++)
			clock_bit(seq[i]);
		clock_free();
	endtask

	task automatic data_byte(input logic [7:0] v);
		for (int i = 0; i < 8; i++)
			clock_bit(v[i]);
		clock_free();
	endtask

	// SCL low, rise with SDA low, SDA up while SCL high, then the fall
	task automatic bus_stop();
		repeat ($urandom_range(1, 2)) put_sample(1'b0, 1'b0);
		put_sample(1'b1, 1'b0);
		repeat ($urandom_range(1, 2)) put_sample(1'b1, 1'b1);
		put_sample(1'b0, 1'b1);
	endtask

	// SDA drops while SCL is high
	task automatic abort_bit();
		put_sample(1'b0, 1'b1);
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b0);
		put_sample(1'b0, 1'b0);
	endtask

	// n bytes read; ends on a NACK or on a stop in the master ACK slot
	task automatic read_frame(input int n, input bit stop_end, input logic [8:0] fix);
		open_frame(1'b1);
		for (int k = 0; k < n; k++) begin
			rd_fix = fix;
			repeat (8) clock_free();
			rd_fix = '0;
			if (k == n - 1 && stop_end)
				bus_stop();
			else
				clock_bit(k == n - 1);
		end
	endtask

	// enough stops to bring the slave back to idle from any state
	task automatic resync();
		repeat (10) bus_stop();
	endtask

	task automatic wait_drained();
		while (words_taken != words_queued || bus_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);   // two-stage pipe is empty well before this
	endtask

	task automatic set_bit_order(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		gen_lsb = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		logic order[4];
		int   goal, pick, n;
		order = '{1'b1, 1'b0, 1'b1, 1'b0};
		lsb_mode = 1'b1;
		scl_q = 1'b1;
		sda_q = 1'b1;
		ph = PH_IDLE;
		nbit = '0;
		rx_byte = '0;
		rise_bit = 1'b0;
		dir_rd = 1'b0;
		target_addr = '0;
		addr_valid = 1'b0;
		tx_byte = '0;
		rd_wait = 1'b0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			set_bit_order(order[p]);
			@(posedge clk);   // fill away from the sender's edge

			if (p == 0) begin
				// write: address 0xFF gets 0x00, address 0x00 gets 0xFF
				open_frame(1'b0);
				data_byte(8'hFF);
				data_byte(8'h00);
				data_byte(8'h00);
				data_byte(8'hFF);
				bus_stop();
				// read with all-ones answer, ACK then NACK
				read_frame(2, 1'b0, 9'h1FF);
				// read with all-zeros answer, ended by a stop in the ACK slot
				read_frame(1, 1'b1, 9'h100);
				// stop in the middle of a data byte
				open_frame(1'b0);
				repeat (3) clock_bit(1'b1);
				bus_stop();
				// start while a data byte is in flight
				open_frame(1'b0);
				repeat (2) clock_bit(1'b0);
				start_frame(1'b1);
				resync();
				// aborted address bit
				start_frame(1'b0);
				clock_bit(1'b1);
				abort_bit();
				resync();
			end

			// running total of about 200 samples per bit-order pass
			goal = (p + 1) * 200;
			while (words_queued < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					open_frame(1'b0);
					n = $urandom_range(1, 5);
					repeat (n)
						data_byte(($urandom_range(0, 7) == 0) ? 8'hFF :
							($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 7)) clock_bit(1'($urandom_range(0, 1)));
					bus_stop();
				end else if (pick < 80) begin
					read_frame($urandom_range(1, 3), $urandom_range(0, 5) == 0, '0);
				end else if (pick < 90) begin
					// broken frame: abort or a fresh start part way through
					open_frame(1'($urandom_range(0, 1)));
					repeat ($urandom_range(0, 9)) clock_bit(1'($urandom_range(0, 1)));
					if ($urandom_range(0, 1))
						abort_bit();
					else
						start_frame(1'($urandom_range(0, 1)));
					resync();
				end else begin
					repeat ($urandom_range(2, 12))
						put_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					resync();
				end
			end
			resync();
		end

		wait_drained();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
